FILE: rtl/nasp_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and match tables for the antenna status parser
// no dependencies
package nasp_pkg;

  localparam int unsigned PQTM_LEN = 18;
  localparam int unsigned KEY_LEN  = 10;
  localparam int unsigned MAG_W    = 10;
  localparam logic [MAG_W-1:0] MAG_CAP = 10'd1023;

  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_NUL    = 8'd0;
  localparam logic [7:0] CHAR_DOLLAR = "$";
  localparam logic [7:0] CHAR_STAR   = "*";
  localparam logic [7:0] CHAR_COMMA  = ",";
  localparam logic [7:0] CHAR_PLUS   = "+";
  localparam logic [7:0] CHAR_MINUS  = "-";

  // held antenna status codes
  localparam logic [2:0] ANT_UNKNOWN = 3'd0;
  localparam logic [2:0] ANT_OPEN    = 3'd1;
  localparam logic [2:0] ANT_SHORT   = 3'd2;
  localparam logic [2:0] ANT_OK      = 3'd3;
  localparam logic [2:0] ANT_OK_INT  = 3'd4;
  localparam logic [2:0] ANT_OK_EXT  = 3'd5;

  // sentence kinds
  localparam logic KIND_PQTM = 1'b0;
  localparam logic KIND_TXT  = 1'b1;

  // prefix flag bits
  localparam int unsigned FLAG_PQTM = 0;
  localparam int unsigned FLAG_TXT  = 1;
  localparam int unsigned FLAG_NUL  = 2;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } atoi_phase_t;

  typedef struct packed {
    atoi_phase_t      phase;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } atoi_upd_t;

  typedef struct packed {
    logic       upd;
    logic [2:0] state;
    logic       chg;
    logic       kind;
  } nasp_result_t;

  function automatic logic [7:0] pqtm_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:  ch = "$";
      5'd1:  ch = "P";
      5'd2:  ch = "Q";
      5'd3:  ch = "T";
      5'd4:  ch = "M";
      5'd5:  ch = "A";
      5'd6:  ch = "N";
      5'd7:  ch = "T";
      5'd8:  ch = "E";
      5'd9:  ch = "N";
      5'd10: ch = "N";
      5'd11: ch = "A";
      5'd12: ch = "S";
      5'd13: ch = "T";
      5'd14: ch = "A";
      5'd15: ch = "T";
      5'd16: ch = "U";
      5'd17: ch = "S";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // position 3..6 of the line against "TXT,"
  function automatic logic [7:0] txt_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd3: ch = "T";
      3'd4: ch = "X";
      3'd5: ch = "T";
      3'd6: ch = ",";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0: ch = "A";
      4'd1: ch = "N";
      4'd2: ch = "T";
      4'd3: ch = "S";
      4'd4: ch = "T";
      4'd5: ch = "A";
      4'd6: ch = "T";
      4'd7: ch = "U";
      4'd8: ch = "S";
      4'd9: ch = "=";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // kmp automaton for "ANTSTATUS=", only the "ANTSTA" state has a longer fallback
  function automatic logic [3:0] kmp_next(input logic [3:0] k, input logic [7:0] c);
    logic [3:0] nk;
    if (c == key_char(k)) begin
      nk = k + 4'd1;
    end else if (k == 4'd6 && c == "N") begin
      nk = 4'd2;
    end else if (c == "A") begin
      nk = 4'd1;
    end else begin
      nk = 4'd0;
    end
    return nk;
  endfunction

  // value words: 0 OK, 1 OPEN, 2 SHORT
  function automatic logic [7:0] val_char(input logic [1:0] i, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'd0;
    case (i)
      2'd0: begin
        case (p)
          3'd0: ch = "O";
          3'd1: ch = "K";
          default: ch = 8'd0;
        endcase
      end
      2'd1: begin
        case (p)
          3'd0: ch = "O";
          3'd1: ch = "P";
          3'd2: ch = "E";
          3'd3: ch = "N";
          default: ch = 8'd0;
        endcase
      end
      2'd2: begin
        case (p)
          3'd0: ch = "S";
          3'd1: ch = "H";
          3'd2: ch = "O";
          3'd3: ch = "R";
          3'd4: ch = "T";
          default: ch = 8'd0;
        endcase
      end
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] val_len(input logic [1:0] i);
    logic [2:0] n;
    case (i)
      2'd0: n = 3'd2;
      2'd1: n = 3'd4;
      2'd2: n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] val_code(input logic [1:0] i);
    logic [2:0] v;
    case (i)
      2'd0: v = ANT_OK;
      2'd1: v = ANT_OPEN;
      2'd2: v = ANT_SHORT;
      default: v = ANT_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/nasp_atoi_field.sv
`timescale 1ns / 1ps
// one character step of the atoi-style number reader for a comma field
// depends on nasp_pkg
module nasp_atoi_field
  import nasp_pkg::*;
(
  input  atoi_phase_t      phase,
  input  logic [7:0]       c,
  input  logic             neg,
  input  logic [MAG_W-1:0] mag,
  output atoi_upd_t        upd
);

  logic             is_dig;
  logic             is_ws;
  logic [MAG_W-1:0] digit;
  logic [13:0]      scaled;

  assign is_dig = (c >= "0") && (c <= "9");
  assign is_ws  = (c == " ") || (c == 8'd9) || (c == 8'd11) || (c == 8'd12);
  assign digit  = MAG_W'(c - "0");
  assign scaled = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {10'd0, c[3:0]};

  // phase next
  always_comb begin
    upd.phase = phase;
    case (phase)
      PH_LEAD: begin
        if (is_ws) upd.phase = PH_LEAD;
        else if (c == CHAR_PLUS || c == CHAR_MINUS) upd.phase = PH_SIGN;
        else if (is_dig) upd.phase = PH_DIGIT;
        else upd.phase = PH_DONE;
      end
      PH_SIGN:  upd.phase = is_dig ? PH_DIGIT : PH_DONE;
      PH_DIGIT: upd.phase = is_dig ? PH_DIGIT : PH_DONE;
      PH_DONE:  upd.phase = PH_DONE;
      default:  upd.phase = PH_DONE;
    endcase
  end

  // sign and magnitude
  always_comb begin
    upd.neg = neg;
    upd.mag = mag;
    case (phase)
      PH_LEAD: begin
        if (!is_ws && c == CHAR_MINUS) upd.neg = 1'b1;
        else if (!is_ws && c != CHAR_PLUS && is_dig) upd.mag = digit;
      end
      PH_SIGN: begin
        if (is_dig) upd.mag = digit;
      end
      PH_DIGIT: begin
        // saturate at the cap
        if (is_dig) upd.mag = (scaled > 14'(MAG_CAP)) ? MAG_CAP : scaled[MAG_W-1:0];
      end
      default: begin
        upd.mag = mag;
      end
    endcase
  end

endmodule

FILE: rtl/nasp_line_parser.sv
`timescale 1ns / 1ps
// per-line parser state and the single-pass update for one character
// depends on nasp_pkg and nasp_atoi_field
module nasp_line_parser
  import nasp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 200
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   c,
  output nasp_result_t result
);

  localparam int unsigned CNT_W = $clog2(LINE_BYTES);

  logic [CNT_W-1:0] line_count, line_count_next;
  logic [2:0]       flags, flags_next;
  logic [3:0]       kp, kp_next;
  logic [2:0]       vmask, vmask_next;
  logic [2:0]       vpos, vpos_next;
  logic [2:0]       cc, cc_next;
  logic             cstop, cstop_next;
  atoi_phase_t      phase, phase_next;
  logic [1:0]       seen, seen_next;
  logic [1:0]       neg, neg_next;
  logic [MAG_W-1:0] mag [2];
  logic [MAG_W-1:0] mag_next [2];
  logic [2:0]       held, held_next;

  logic             fsel;
  logic [2:0]       cc_inc;
  atoi_upd_t        aupd;
  logic             is_eol;
  logic [1:0]       fvalid;
  logic [2:0]       pro_tag, txt_tag;
  logic             pro_hit, txt_hit;

  assign fsel   = (cc == 3'd4);
  assign cc_inc = (cc < 3'd5) ? cc + 3'd1 : cc;
  assign is_eol = (c == CHAR_LF) || (c == CHAR_CR);

  nasp_atoi_field u_atoi (
    .phase (phase),
    .c     (c),
    .neg   (neg[fsel]),
    .mag   (mag[fsel]),
    .upd   (aupd)
  );

  // field reads as -1 when missing or negative nonzero
  always_comb begin
    for (int f = 0; f < 2; f++) begin
      fvalid[f] = seen[f] && !(neg[f] && mag[f] != '0);
    end
  end

  always_comb begin
    pro_tag = ANT_UNKNOWN;
    if (fvalid[0] && (mag[0] == 10'd0 || mag[0] == 10'd3)) begin
      pro_tag = ANT_OPEN;
    end else if (fvalid[0] && mag[0] == 10'd1) begin
      pro_tag = ANT_SHORT;
    end else if (fvalid[0] && mag[0] == 10'd2) begin
      if (fvalid[1] && mag[1] == 10'd2) pro_tag = ANT_OK_EXT;
      else if (fvalid[1] && mag[1] == 10'd1) pro_tag = ANT_OK_INT;
      else pro_tag = ANT_OK;
    end
  end

  always_comb begin
    txt_tag = ANT_UNKNOWN;
    for (int i = 0; i < 3; i++) begin
      if (vmask[i] && val_len(2'(i)) <= vpos) txt_tag = val_code(2'(i));
    end
  end

  assign pro_hit = (line_count > CNT_W'(PQTM_LEN)) && flags[FLAG_PQTM];
  assign txt_hit = (line_count > CNT_W'(6)) && flags[FLAG_TXT] && (kp >= 4'(KEY_LEN));

  always_comb begin
    line_count_next = line_count;
    flags_next      = flags;
    kp_next         = kp;
    vmask_next      = vmask;
    vpos_next       = vpos;
    cc_next         = cc;
    cstop_next      = cstop;
    phase_next      = phase;
    seen_next       = seen;
    neg_next        = neg;
    mag_next[0]     = mag[0];
    mag_next[1]     = mag[1];
    held_next       = held;
    result          = '0;
    result.state    = held;

    if (is_eol || line_count >= CNT_W'(LINE_BYTES - 1)) begin
      if (is_eol && pro_hit) begin
        result.upd  = 1'b1;
        result.kind = KIND_PQTM;
        result.chg  = (pro_tag != held);
        held_next   = pro_tag;
      end else if (is_eol && txt_hit) begin
        result.upd  = 1'b1;
        result.kind = KIND_TXT;
        result.chg  = (txt_tag != held);
        held_next   = txt_tag;
      end
      result.state = held_next;
      // line is emptied on end of line or on overflow
      line_count_next = '0;
      flags_next      = 3'b011;
      kp_next         = '0;
      vmask_next      = 3'b111;
      vpos_next       = '0;
      cc_next         = '0;
      cstop_next      = 1'b0;
      phase_next      = PH_DONE;
      seen_next       = '0;
      neg_next        = '0;
      mag_next[0]     = '0;
      mag_next[1]     = '0;
    end else begin
      if (line_count < CNT_W'(PQTM_LEN) && c != pqtm_char(line_count[4:0]))
        flags_next[FLAG_PQTM] = 1'b0;
      if (line_count == '0 && c != CHAR_DOLLAR)
        flags_next[FLAG_TXT] = 1'b0;
      if (line_count >= CNT_W'(3) && line_count <= CNT_W'(6) && c != txt_char(line_count[2:0]))
        flags_next[FLAG_TXT] = 1'b0;

      if (kp >= 4'(KEY_LEN)) begin
        if (vpos < 3'd5) begin
          for (int i = 0; i < 3; i++) begin
            if (val_len(2'(i)) > vpos && val_char(2'(i), vpos) != c) vmask_next[i] = 1'b0;
          end
          vpos_next = vpos + 3'd1;
        end
      end else if (!flags[FLAG_NUL]) begin
        if (c == CHAR_NUL) flags_next[FLAG_NUL] = 1'b1;
        else kp_next = kmp_next(kp, c);
      end

      if (!cstop) begin
        if (c == CHAR_STAR || c == CHAR_NUL) begin
          cstop_next = 1'b1;
        end else if (c == CHAR_COMMA) begin
          cc_next = cc_inc;
          if (cc_inc == 3'd3 || cc_inc == 3'd4) begin
            seen_next[cc_inc == 3'd4] = 1'b1;
            phase_next = PH_LEAD;
          end else begin
            phase_next = PH_DONE;
          end
        end else if (cc == 3'd3 || cc == 3'd4) begin
          phase_next      = aupd.phase;
          neg_next[fsel]  = aupd.neg;
          mag_next[fsel]  = aupd.mag;
        end
      end

      line_count_next = line_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      flags      <= 3'b011;
      kp         <= '0;
      vmask      <= 3'b111;
      vpos       <= '0;
      cc         <= '0;
      cstop      <= 1'b0;
      phase      <= PH_DONE;
      seen       <= '0;
      neg        <= '0;
      mag[0]     <= '0;
      mag[1]     <= '0;
      held       <= ANT_UNKNOWN;
    end else if (step) begin
      line_count <= line_count_next;
      flags      <= flags_next;
      kp         <= kp_next;
      vmask      <= vmask_next;
      vpos       <= vpos_next;
      cc         <= cc_next;
      cstop      <= cstop_next;
      phase      <= phase_next;
      seen       <= seen_next;
      neg        <= neg_next;
      mag[0]     <= mag_next[0];
      mag[1]     <= mag_next[1];
      held       <= held_next;
    end
  end

endmodule

FILE: rtl/nmea_antenna_status_parser_core.sv
`timescale 1ns / 1ps
// top level of the nmea antenna status parser: input register, parser, result register
// depends on nasp_pkg and nasp_line_parser
//
// usage
//   s_* channel takes one received nmea character per item in s_tdata
//   m_* channel gives exactly one result item for every input item, in order
//   a line ends on cr or lf; at that point a $PQTMANTENNASTATUS sentence or a
//   $xxTXT sentence with ANTSTATUS= updates the held antenna status (OK/OPEN/SHORT or unknown)
//   a character that would make the line LINE_BYTES long empties the line
// path
//   an accepted item is registered in the input register, processed in a single pass
//   as it moves into the result register and is then offered on m_tvalid
// throughput
//   one item per cycle while m_tready does not stall the result register; the only loop
//   is the per-line parser state, updated in a single pass from the registered character
// reset
//   rst (synchronous) empties the line, sets the held status to unknown and
//   drops any items in flight
// stall
//   while m_tready is low the result register holds; one more item waits in the
//   input register and then s_tready goes low until the result is taken
module nmea_antenna_status_parser_core
  import nasp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 200
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] status_updated, [3:1] antenna_state, [4] state_changed, [7:5] zero
  output logic       m_tuser    // [0] sentence_kind
);

  // input register
  logic         in_valid;
  logic [7:0]   in_byte;
  // result register
  nasp_result_t res;
  nasp_result_t res_next;
  // character moves from the input register into the parser and result register
  logic         advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  nasp_line_parser #(
    .LINE_BYTES (LINE_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .c      (in_byte),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'b000, res.chg, res.state, res.upd};
  assign m_tuser = res.kind;

  // a processed item always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed item did not reach the result register");

  // with an empty result register the input side never stalls
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result register empty");

  // a change or a txt kind is only reported together with an update
  a_flags_need_update: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.chg || res.kind) |-> res.upd)
    else $error("change or kind flagged without an update");

  // held status stays within the defined codes
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.state <= ANT_OK_EXT)
    else $error("antenna state out of range");

  // without an update the reported status repeats the held one
  a_no_update_holds: assert property (@(posedge clk) disable iff (rst)
    advance && !res_next.upd |-> res_next.state == u_parser.held)
    else $error("status moved without an update");

endmodule
